@@ rtl/bitplane_tile_row_decoder_core_macros.svh @@
// Assertion macros shared by the bit-plane tile row decoder RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BITPLANE_TILE_ROW_DECODER_CORE_MACROS_SVH
`define BITPLANE_TILE_ROW_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/btrd_pkg.sv @@
// Package for the bit-plane tile row decoder: mode and class codes, plane mask
// function and the control struct passed to the class merge stage. No dependencies.
package btrd_pkg;

   localparam int unsigned NumPlanes = 8;
   localparam int unsigned NumPixels = 8;

   localparam logic [1:0] MODE_TWO_PLANES   = 2'd0;
   localparam logic [1:0] MODE_FOUR_PLANES  = 2'd1;
   localparam logic [1:0] MODE_EIGHT_PLANES = 2'd2;

   localparam logic [1:0] CLASS_MIXED       = 2'd0;
   localparam logic [1:0] CLASS_OPAQUE      = 2'd1;
   localparam logic [1:0] CLASS_TRANSPARENT = 2'd2;
   localparam logic [1:0] CLASS_NONE        = 2'd3;

   typedef logic [NumPlanes-1:0] plane_mask_type;

   typedef struct packed {
      logic accept;
      logic last_row;
   } merge_ctrl_type;

   // Planes above the active count are masked off; the unused mode code
   // behaves as eight planes.
   function automatic plane_mask_type plane_mask(input logic [1:0] mode);
      plane_mask_type mask;
      case (mode)
         MODE_TWO_PLANES:  mask = 8'h03;
         MODE_FOUR_PLANES: mask = 8'h0F;
         default:          mask = 8'hFF;
      endcase
      return mask;
   endfunction

endpackage

@@ rtl/bitplane_tile_row_decoder_core.sv @@
// Top level of the bit-plane tile row decoder: eight pixel lanes, the class
// merge stage and the result register. Depends on btrd_pkg, btrd_pixel_lane,
// btrd_class_merge and the assertion macro header.
//
// Usage
// Each transfer on the req_ channel carries one tile row as eight gathered
// plane bytes (byte k is plane k) and the tile number; req_tlast marks the
// eighth row of a tile. Each row yields exactly one transfer on the rsp_
// channel with the eight pixel indices, the running tile class and the tile
// number; rsp_tlast is set on the last row, when the class is final.
// The csr_ channel writes the plane mode (two, four or eight planes); it is
// always ready and should only be written while no rows are in flight.
//
// An accepted row is loaded into the result register and offered on rsp_
// in the following cycle. Throughput is one row per cycle, set by the single result
// register that follows the lane and merge logic. When the receiver stalls,
// the result register holds and req_tready drops until the result is
// taken; a row is accepted in the same cycle as the waiting result leaves.
// Reset sets the plane mode to four planes, restarts the tile class and
// empties the result register.
`include "bitplane_tile_row_decoder_core_macros.svh"

module bitplane_tile_row_decoder_core
   import btrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Plane mode write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data,    // plane_mode
   // Row input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // [63:0] plane_bytes, [75:64] tile_index, rest zero
   input  logic        req_tlast,   // last_row
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] pixel_row, [65:64] tile_class,
                                    // [77:66] tile_number, rest zero
   output logic        rsp_tlast    // class_valid
);

   logic [1:0]           plane_mode_ff;
   logic [1:0]           plane_mode_in;
   plane_mask_type       mask;
   logic [63:0]          plane_bytes;
   logic [11:0]          tile_index;
   logic                 req_accept;
   logic                 rsp_accept;
   plane_mask_type       column_bits [NumPixels];
   logic [63:0]          pixel_row;
   logic [NumPixels-1:0] lane_nonzero;
   logic [1:0]           row_class;
   merge_ctrl_type       merge_ctrl;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [63:0]          pixel_row_ff;
   logic [1:0]           tile_class_ff;
   logic                 class_valid_ff;
   logic [11:0]          tile_number_ff;

   // The mode register is written whenever a transfer arrives; only the
   // three defined codes are expected, and the spare code acts as eight planes.
   assign csr_ready     = 1'b1;
   assign plane_mode_in = (csr_valid && csr_ready) ? csr_data : plane_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_mode_ff <= MODE_FOUR_PLANES;
      end else begin
         plane_mode_ff <= plane_mode_in;
      end
   end

   assign mask        = plane_mask(plane_mode_ff);
   assign plane_bytes = req_tdata[63:0];
   assign tile_index  = req_tdata[75:64];

   // The result register may take a new row when it is empty or its current
   // content leaves in this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;

   // Pixel i takes bit (7 - i) of every plane, with plane k as index bit k.
   for (genvar i = 0; i < NumPixels; i++) begin : g_lane
      for (genvar k = 0; k < NumPlanes; k++) begin : g_plane
         assign column_bits[i][k] = plane_bytes[8*k + (7 - i)];
      end

      btrd_pixel_lane u_lane (
         .column_bits (column_bits[i]),
         .mask        (mask),
         .pixel       (pixel_row[8*i +: 8]),
         .nonzero     (lane_nonzero[i])
      );
   end

   assign merge_ctrl.accept   = req_accept;
   assign merge_ctrl.last_row = req_tlast;

   btrd_class_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .lane_nonzero (lane_nonzero),
      .ctrl         (merge_ctrl),
      .row_class    (row_class)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only with an accepted row and need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pixel_row_ff   <= pixel_row;
         tile_class_ff  <= row_class;
         class_valid_ff <= req_tlast;
         tile_number_ff <= tile_index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, tile_number_ff, tile_class_ff, pixel_row_ff};
   assign rsp_tlast  = class_valid_ff;

   `BTRD_ASSERT_NEXT(a_row_gives_result, clock, reset, req_accept, rsp_valid_ff, "accepted row produced no result")
   `BTRD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !req_accept, "waiting result overwritten")
   `BTRD_ASSERT_NEXT(a_echo_tile, clock, reset, req_accept, tile_number_ff == $past(tile_index), "tile number not echoed")

endmodule

@@ rtl/btrd_pixel_lane.sv @@
// One pixel lane of the bit-plane tile row decoder: masks one column of plane
// bits into a pixel index and flags a nonzero pixel. Depends on btrd_pkg.
module btrd_pixel_lane
   import btrd_pkg::*;
(
   input  plane_mask_type column_bits,
   input  plane_mask_type mask,
   output logic [7:0]     pixel,
   output logic           nonzero
);

   assign pixel   = column_bits & mask;
   assign nonzero = |pixel;

endmodule

@@ rtl/btrd_class_merge.sv @@
// Merge stage of the bit-plane tile row decoder: combines the lane flags with
// the running tile class and holds the class accumulator. Depends on btrd_pkg.
`include "bitplane_tile_row_decoder_core_macros.svh"

module btrd_class_merge
   import btrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NumPixels-1:0] lane_nonzero,
   input  merge_ctrl_type       ctrl,
   output logic [1:0]           row_class
);

   logic [1:0] class_acc_ff;
   logic [1:0] class_acc_in;
   logic       all_nonzero;
   logic       all_zero;

   // Any mix of zero and nonzero pixels within a row clears both class bits.
   always_comb begin
      all_nonzero = &lane_nonzero;
      all_zero    = ~|lane_nonzero;
      if (all_nonzero) begin
         row_class = class_acc_ff & CLASS_OPAQUE;
      end else if (all_zero) begin
         row_class = class_acc_ff & CLASS_TRANSPARENT;
      end else begin
         row_class = CLASS_MIXED;
      end
   end

   always_comb begin
      class_acc_in = class_acc_ff;
      if (ctrl.accept) begin
         class_acc_in = ctrl.last_row ? CLASS_NONE : row_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_acc_ff <= CLASS_NONE;
      end else begin
         class_acc_ff <= class_acc_in;
      end
   end

   `BTRD_ASSERT_NEXT(a_last_restarts_class, clock, reset, ctrl.accept && ctrl.last_row, class_acc_ff == CLASS_NONE, "class not restarted after last row")
   `BTRD_ASSERT_NEXT(a_row_keeps_class, clock, reset, ctrl.accept && !ctrl.last_row, class_acc_ff == $past(row_class), "running class not kept")
   `BTRD_ASSERT_NOW(a_class_narrows, clock, reset, class_acc_ff != CLASS_NONE, (row_class & ~class_acc_ff) == 2'd0, "class gained a bit")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the bit-plane tile row decoder core.
// Depends on btrd_pkg and bitplane_tile_row_decoder_core; drives rows, plane mode
// writes and random stalls, and checks every result against its own row decoder.
`timescale 1ns / 100ps

module tb
   import btrd_pkg::*;
();

   // The mode code that the block does not name; it must behave as eight planes.
   localparam logic [1:0] MODE_UNDEFINED = 2'd3;
   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned SettleCycles = 3;
   localparam int unsigned LongHold = 100;

   typedef enum logic [1:0] {
      JOB_ROW,
      JOB_DRAIN,
      JOB_MODE
   } job_kind_type;

   // One entry of the sender's schedule: a tile row, a pause until the block has
   // gone quiet, or a plane mode write.
   typedef struct {
      job_kind_type kind;
      logic [63:0]  planes;
      logic         last_row;
      logic [11:0]  tile;
      logic [1:0]   mode;
      int unsigned  gap;
   } row_job_type;

   typedef struct {
      logic [63:0] pixel_row;
      logic [1:0]  tile_class;
      logic        class_valid;
      logic [11:0] tile_number;
   } decoded_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   row_job_type     row_jobs_q[$];
   decoded_row_type expected_rows_q[$];

   // Our own copy of the block's state: the plane mode and the running tile class.
   logic [1:0]  plane_mode_copy = MODE_FOUR_PLANES;
   logic [1:0]  class_so_far = CLASS_NONE;

   // Handshake outcomes of the last rising edge, read by the processes that drive
   // at the falling edge.
   logic        row_taken = 1'b0;
   logic        result_taken = 1'b0;
   logic        mode_taken = 1'b0;

   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   bitplane_tile_row_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decodes one row under the current plane mode and advances the tile class.
   // Pixel i takes bit 7 - i of each active plane, plane k giving index bit k.
   function automatic decoded_row_type decode_tile_row(input logic [63:0] planes,
                                                       input logic last_row,
                                                       input logic [11:0] tile);
      decoded_row_type res;
      int unsigned depth;
      int unsigned i;
      int unsigned k;
      logic [7:0] px;
      logic [1:0] cls;
      case (plane_mode_copy)
         MODE_TWO_PLANES:  depth = 2;
         MODE_FOUR_PLANES: depth = 4;
         default:          depth = 8;
      endcase
      cls = class_so_far;
      res.pixel_row = '0;
      for (i = 0; i < 8; i++) begin
         px = '0;
         for (k = 0; k < depth; k++) begin
            px[k] = planes[8*k + 7 - i];
         end
         res.pixel_row[8*i +: 8] = px;
         // A lit pixel rules out a transparent tile, a clear one an opaque tile.
         cls = (px != 8'd0) ? (cls & CLASS_OPAQUE) : (cls & CLASS_TRANSPARENT);
      end
      res.tile_class = cls;
      res.class_valid = last_row;
      res.tile_number = tile;
      class_so_far = last_row ? CLASS_NONE : cls;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_row(input logic [63:0] planes, input logic last_row,
                          input logic [11:0] tile, input int unsigned gap);
      row_job_type job;
      job.kind = JOB_ROW;
      job.planes = planes;
      job.last_row = last_row;
      job.tile = tile;
      job.mode = '0;
      job.gap = gap;
      row_jobs_q.push_back(job);
   endtask

   // The sender stops until every expected result has come back.
   task automatic add_pause();
      row_job_type job;
      job.kind = JOB_DRAIN;
      job.planes = '0;
      job.last_row = 1'b0;
      job.tile = '0;
      job.mode = '0;
      job.gap = SettleCycles;
      row_jobs_q.push_back(job);
   endtask

   // Plane mode writes are only made once the block has gone idle.
   task automatic add_mode(input logic [1:0] mode);
      row_job_type job;
      add_pause();
      job.kind = JOB_MODE;
      job.planes = '0;
      job.last_row = 1'b0;
      job.tile = '0;
      job.mode = mode;
      job.gap = 0;
      row_jobs_q.push_back(job);
   endtask

   // Monitor: samples every handshake at the rising edge, keeps the decoder copy
   // in step and checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      decoded_row_type want;
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         row_taken = !reset && req_tvalid && req_tready;
         result_taken = !reset && rsp_tvalid && rsp_tready;
         mode_taken = !reset && csr_valid && csr_ready;
         if (mode_taken) begin
            plane_mode_copy = csr_data;
         end
         if (result_taken) begin
            if (expected_rows_q.size() == 0) begin
               $error("result transfer with no row outstanding: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_rows_q.pop_front();
               check_field("pixel_row", want.pixel_row, rsp_tdata[63:0]);
               check_field("tile_class", 64'(want.tile_class), 64'(rsp_tdata[65:64]));
               check_field("tile_number", 64'(want.tile_number), 64'(rsp_tdata[77:66]));
               check_field("rsp_tdata padding", 64'd0, 64'(rsp_tdata[79:78]));
               check_field("class_valid", 64'(want.class_valid), 64'(rsp_tlast));
            end
         end
         // The result of this edge belongs to an older row, so the new
         // expectation is queued after the check.
         if (row_taken) begin
            expected_rows_q.push_back(decode_tile_row(req_tdata[63:0], req_tlast,
                                                      req_tdata[75:64]));
         end
      end
   end

   // Driver: works through the schedule at the falling edge. Each control signal
   // is assigned once per step, so a row offered straight after another keeps
   // req_tvalid high throughout.
   always @(negedge clock) begin
      logic offer;
      logic mode_offer;
      row_job_type job;
      offer = req_tvalid && !row_taken;
      mode_offer = csr_valid && !mode_taken;
      if (!reset && !offer && !mode_offer && row_jobs_q.size() != 0) begin
         job = row_jobs_q[0];
         case (job.kind)
            JOB_ROW: begin
               if (job.gap != 0) begin
                  row_jobs_q[0].gap = job.gap - 1;
               end else begin
                  void'(row_jobs_q.pop_front());
                  req_tdata <= {4'd0, job.tile, job.planes};
                  req_tlast <= job.last_row;
                  offer = 1'b1;
               end
            end
            JOB_DRAIN: begin
               // After the last result has come back, count down the settle gap before moving on.
               if (expected_rows_q.size() == 0) begin
                  if (job.gap != 0) begin
                     row_jobs_q[0].gap = job.gap - 1;
                  end else begin
                     void'(row_jobs_q.pop_front());
                  end
               end
            end
            default: begin
               void'(row_jobs_q.pop_front());
               csr_data <= job.mode;
               mode_offer = 1'b1;
            end
         endcase
      end
      req_tvalid <= offer;
      csr_valid <= mode_offer;
   end

   // Receiver: after each result transfer it draws a random stall, with calm
   // stretches that never stall. Twice it holds off for a long stretch so
   // that the result register fills and the input backs up.
   always @(negedge clock) begin
      static int unsigned results_seen = 0;
      static int unsigned stall_left = 0;
      static int unsigned hold_left = 0;
      static logic calm = 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (result_taken) begin
            results_seen++;
            if (results_seen % 40 == 0) begin
               calm = ($urandom_range(0, 2) == 0);
            end
            stall_left = calm ? 0 : $urandom_range(0, 12);
            if (results_seen == 120 || results_seen == 320) begin
               hold_left = LongHold;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: a directed opening, then segments of random tiles, each under a
   // fresh plane mode, and finally the wait for the last results.
   initial begin
      logic [1:0]  seg_mode;
      logic [63:0] planes;
      logic [11:0] tile;
      int unsigned seg;
      int unsigned t;
      int unsigned r;
      int unsigned tile_rows;
      int unsigned style;
      int unsigned rows_in_seg;
      logic        seg_calm;

      // Four planes after reset: clear row, fully lit row, then the final class.
      add_row(64'h0, 1'b0, 12'd0, 0);
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 12'hFFF, 0);
      add_row(64'h0123_4567_89AB_CDEF, 1'b1, 12'hFFF, 2);
      // Only the unused upper planes carry bits: every pixel reads as zero.
      add_row(64'hFFFF_FFFF_0000_0000, 1'b1, 12'h800, 0);
      // A wholly transparent tile and a wholly opaque one.
      for (r = 0; r < 8; r++) begin
         add_row(64'hA5A5_5A5A_0000_0000, r == 7, 12'h155, 0);
      end
      add_row(64'h0000_0000_0000_00FF, 1'b0, 12'h2AA, 1);
      add_row(64'h0000_0000_FF00_0000, 1'b1, 12'h2AA, 0);
      // Two planes: bits above plane 1 are ignored.
      add_mode(MODE_TWO_PLANES);
      add_row(64'hFFFF_FFFF_FFFF_0000, 1'b1, 12'h001, 0);
      add_row(64'h0000_0000_0000_AA55, 1'b1, 12'h002, 3);
      // Eight planes, then the undefined code that must act as eight.
      add_mode(MODE_EIGHT_PLANES);
      add_row(64'h8000_0000_0000_0000, 1'b0, 12'h7FF, 0);
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 12'h7FF, 0);
      add_mode(MODE_UNDEFINED);
      add_row(64'h0102_0408_1020_4080, 1'b1, 12'h400, 0);
      add_row(64'hFF00_0000_0000_0000, 1'b1, 12'h400, 0);

      for (seg = 0; seg < 8; seg++) begin
         seg_mode = (seg < 4) ? 2'(seg) : 2'($urandom_range(0, 3));
         add_mode(seg_mode);
         seg_calm = ($urandom_range(0, 3) == 0);
         rows_in_seg = 0;
         t = 0;
         while (rows_in_seg < 45) begin
            // Mostly whole tiles of eight rows; now and then a short or long run.
            tile_rows = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 8;
            style = $urandom_range(0, 2);
            tile = 12'($urandom_range(0, 4095));
            for (r = 0; r < tile_rows; r++) begin
               planes = {$urandom, $urandom};
               if ($urandom_range(0, 9) != 0) begin
                  if (style == 1) begin
                     planes[7:0] = 8'hFF;
                  end else if (style == 2) begin
                     case (seg_mode)
                        MODE_TWO_PLANES:  planes[15:0] = '0;
                        MODE_FOUR_PLANES: planes[31:0] = '0;
                        default:          planes = '0;
                     endcase
                  end
               end
               add_row(planes, (r == tile_rows - 1) && ($urandom_range(0, 9) != 0), tile,
                       seg_calm ? 0 : $urandom_range(0, 12));
               rows_in_seg++;
            end
            t++;
            // Once, the sender stops mid-run until every result is back.
            if (seg == 5 && t == 2) begin
               add_pause();
            end
         end
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (row_jobs_q.size() != 0 || req_tvalid || csr_valid
             || expected_rows_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles + 5) @(posedge clock);
      if (mismatches == 0 && expected_rows_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
